@@ rtl/core/sle_pkg.sv @@
// Shared types, constants and keymap tables of the scancode line editor.
package sle_pkg;

  localparam int LINE_CAPACITY = 63;
  localparam int FILL_W = $clog2(LINE_CAPACITY + 1);
  localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
  localparam int CHAR_W = 7;
  localparam int SCAN_W = 8;

  localparam logic [SCAN_W-1:0] SC_PREFIX     = 8'hE0;
  localparam logic [SCAN_W-1:0] SC_LSHIFT     = 8'h2A;
  localparam logic [SCAN_W-1:0] SC_RSHIFT     = 8'h36;
  localparam logic [SCAN_W-1:0] SC_LSHIFT_REL = 8'hAA;
  localparam logic [SCAN_W-1:0] SC_RSHIFT_REL = 8'hB6;
  localparam logic [SCAN_W-1:0] SC_CAPS       = 8'h3A;
  localparam int                SC_REL_BIT    = 7;

  localparam logic [CHAR_W-1:0] CH_NONE      = 7'h00;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 7'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 7'h0A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A   = 7'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z   = 7'h7A;
  localparam logic [CHAR_W-1:0] CH_CASE_OFS  = 7'h20;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_BACK = 2'd1,
    KIND_LINE = 2'd2,
    KIND_END  = 2'd3
  } sle_kind_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_CHAR,
    OP_BACK,
    OP_ENTER
  } sle_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LD,
    ST_END
  } sle_state_e;

  typedef struct packed {
    sle_op_e           op;
    logic [CHAR_W-1:0] ch;
  } sle_act_t;

  // US layout, unshifted.
  function automatic logic [CHAR_W-1:0] plain_char(input logic [6:0] code);
    logic [CHAR_W-1:0] c;
    case (code)
      7'h01: c = 7'h1B;  7'h02: c = 7'h31;  7'h03: c = 7'h32;  7'h04: c = 7'h33;
      7'h05: c = 7'h34;  7'h06: c = 7'h35;  7'h07: c = 7'h36;  7'h08: c = 7'h37;
      7'h09: c = 7'h38;  7'h0A: c = 7'h39;  7'h0B: c = 7'h30;  7'h0C: c = 7'h2D;
      7'h0D: c = 7'h3D;  7'h0E: c = 7'h08;  7'h0F: c = 7'h09;  7'h10: c = 7'h71;
      7'h11: c = 7'h77;  7'h12: c = 7'h65;  7'h13: c = 7'h72;  7'h14: c = 7'h74;
      7'h15: c = 7'h79;  7'h16: c = 7'h75;  7'h17: c = 7'h69;  7'h18: c = 7'h6F;
      7'h19: c = 7'h70;  7'h1A: c = 7'h5B;  7'h1B: c = 7'h5D;  7'h1C: c = 7'h0A;
      7'h1E: c = 7'h61;  7'h1F: c = 7'h73;  7'h20: c = 7'h64;  7'h21: c = 7'h66;
      7'h22: c = 7'h67;  7'h23: c = 7'h68;  7'h24: c = 7'h6A;  7'h25: c = 7'h6B;
      7'h26: c = 7'h6C;  7'h27: c = 7'h3B;  7'h28: c = 7'h27;  7'h29: c = 7'h60;
      7'h2B: c = 7'h5C;  7'h2C: c = 7'h7A;  7'h2D: c = 7'h78;  7'h2E: c = 7'h63;
      7'h2F: c = 7'h76;  7'h30: c = 7'h62;  7'h31: c = 7'h6E;  7'h32: c = 7'h6D;
      7'h33: c = 7'h2C;  7'h34: c = 7'h2E;  7'h35: c = 7'h2F;  7'h37: c = 7'h2A;
      7'h39: c = 7'h20;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

  // US layout with shift held.
  function automatic logic [CHAR_W-1:0] shifted_char(input logic [6:0] code);
    logic [CHAR_W-1:0] c;
    case (code)
      7'h01: c = 7'h1B;  7'h02: c = 7'h21;  7'h03: c = 7'h40;  7'h04: c = 7'h23;
      7'h05: c = 7'h24;  7'h06: c = 7'h25;  7'h07: c = 7'h5E;  7'h08: c = 7'h26;
      7'h09: c = 7'h2A;  7'h0A: c = 7'h28;  7'h0B: c = 7'h29;  7'h0C: c = 7'h5F;
      7'h0D: c = 7'h2B;  7'h0E: c = 7'h08;  7'h0F: c = 7'h09;  7'h10: c = 7'h51;
      7'h11: c = 7'h57;  7'h12: c = 7'h45;  7'h13: c = 7'h52;  7'h14: c = 7'h54;
      7'h15: c = 7'h59;  7'h16: c = 7'h55;  7'h17: c = 7'h49;  7'h18: c = 7'h4F;
      7'h19: c = 7'h50;  7'h1A: c = 7'h7B;  7'h1B: c = 7'h7D;  7'h1C: c = 7'h0A;
      7'h1E: c = 7'h41;  7'h1F: c = 7'h53;  7'h20: c = 7'h44;  7'h21: c = 7'h46;
      7'h22: c = 7'h47;  7'h23: c = 7'h48;  7'h24: c = 7'h4A;  7'h25: c = 7'h4B;
      7'h26: c = 7'h4C;  7'h27: c = 7'h3A;  7'h28: c = 7'h22;  7'h29: c = 7'h7E;
      7'h2B: c = 7'h7C;  7'h2C: c = 7'h5A;  7'h2D: c = 7'h58;  7'h2E: c = 7'h43;
      7'h2F: c = 7'h56;  7'h30: c = 7'h42;  7'h31: c = 7'h4E;  7'h32: c = 7'h4D;
      7'h33: c = 7'h3C;  7'h34: c = 7'h3E;  7'h35: c = 7'h3F;  7'h37: c = 7'h2A;
      7'h39: c = 7'h20;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/sle_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module sle_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/sle_keymap.sv @@
// Keyboard flag tracking and scancode-to-action decoding.
module sle_keymap (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [sle_pkg::SCAN_W-1:0] scan_code_i,
  output sle_pkg::sle_act_t          act_o
);
  import sle_pkg::*;

  logic shift_q, shift_d;
  logic caps_q, caps_d;
  logic prefix_q, prefix_d;
  logic [CHAR_W-1:0] mapped;
  logic is_shift_make, is_shift_break;

  assign is_shift_make  = (scan_code_i == SC_LSHIFT) || (scan_code_i == SC_RSHIFT);
  assign is_shift_break = (scan_code_i == SC_LSHIFT_REL) || (scan_code_i == SC_RSHIFT_REL);

  // Caps lock only upper-cases letters, and only while shift is up.
  always_comb begin
    if (shift_q) begin
      mapped = shifted_char(scan_code_i[6:0]);
    end else begin
      mapped = plain_char(scan_code_i[6:0]);
      if (caps_q && mapped >= CH_LOWER_A && mapped <= CH_LOWER_Z) begin
        mapped = mapped - CH_CASE_OFS;
      end
    end
  end

  always_comb begin
    shift_d   = shift_q;
    caps_d    = caps_q;
    prefix_d  = prefix_q;
    act_o.op  = OP_NONE;
    act_o.ch  = mapped;
    if (scan_code_i == SC_PREFIX) begin
      prefix_d = 1'b1;
    end else if (prefix_q) begin
      prefix_d = 1'b0;
    end else if (is_shift_make) begin
      shift_d = 1'b1;
    end else if (is_shift_break) begin
      shift_d = 1'b0;
    end else if (scan_code_i == SC_CAPS) begin
      caps_d = ~caps_q;
    end else if (!scan_code_i[SC_REL_BIT]) begin
      if (mapped == CH_NEWLINE) begin
        act_o.op = OP_ENTER;
      end else if (mapped == CH_BACKSPACE) begin
        act_o.op = OP_BACK;
      end else if (mapped != CH_NONE) begin
        act_o.op = OP_CHAR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= 1'b0;
      caps_q   <= 1'b0;
      prefix_q <= 1'b0;
    end else if (accept_i) begin
      shift_q  <= shift_d;
      caps_q   <= caps_d;
      prefix_q <= prefix_d;
    end
  end

endmodule

@@ rtl/core/scancode_line_editor.sv @@
// Top level of the scancode line editor: line store, fill count and result sequencer.
// An echo or an empty line's end marker is registered in the cycle after its word is taken.
// A scancode word is taken when the editor is idle and the output register is free or drains.
// Enter with stored characters sends each through the store's read register and the output
// register; the single read port gives one char per unstalled cycle, then the end marker.
// Reset clears the flags, the fill count and the output valid; store contents stay undefined.
module scancode_line_editor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [sle_pkg::SCAN_W-1:0]  scan_code_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  kind_o,
  output logic [sle_pkg::CHAR_W-1:0]  char_code_o,
  output logic                        last_o
);
  import sle_pkg::*;

  sle_state_e state_q, state_d;
  sle_act_t   act;

  // Fill count and the read index used while a line is streamed out.
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [FILL_W-1:0] idx_q, idx_d;
  logic [FILL_W-1:0] idx_next;

  // Output register.
  logic              out_valid_q, out_valid_d;
  sle_kind_e         kind_q, kind_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              last_q, last_d;

  // Line store port signals.
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  logic slot_free;
  logic accept;
  logic store_full;

  // The output register can take a new word when empty or when it drains now.
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && slot_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign idx_next   = idx_q + 1'b1;
  assign store_full = (fill_q >= FILL_W'(LINE_CAPACITY));

  sle_keymap u_keymap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .scan_code_i (scan_code_i),
    .act_o       (act)
  );

  sle_ram #(
    .Width (CHAR_W),
    .Depth (LINE_CAPACITY)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (act.ch),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state. Streaming only starts when there is something stored; an empty line
  // produces the end marker straight from the idle state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && act.op == OP_ENTER && fill_q != '0) begin
          state_d = ST_LD;
        end
      end
      ST_LD: begin
        if (slot_free && idx_next == fill_q) begin
          state_d = ST_END;
        end
      end
      ST_END: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and store control. Writes happen only in the idle state and reads only on Enter
  // or while streaming, so the store never sees a read and a write to one entry at once.
  // A read is issued only when the previous read word is consumed, so the RAM's
  // read register doubles as the holding stage while the output is stalled.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    char_d      = char_q;
    last_d      = last_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = fill_q[ADDR_W-1:0];
    ram_raddr   = idx_q[ADDR_W-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (act.op)
            OP_CHAR: begin
              if (!store_full) begin
                ram_we      = 1'b1;
                fill_d      = fill_q + 1'b1;
                out_valid_d = 1'b1;
                kind_d      = KIND_ECHO;
                char_d      = act.ch;
                last_d      = 1'b1;
              end
            end
            OP_BACK: begin
              if (fill_q != '0) begin
                fill_d      = fill_q - 1'b1;
                out_valid_d = 1'b1;
                kind_d      = KIND_BACK;
                char_d      = CH_NONE;
                last_d      = 1'b1;
              end
            end
            OP_ENTER: begin
              if (fill_q == '0) begin
                out_valid_d = 1'b1;
                kind_d      = KIND_END;
                char_d      = CH_NONE;
                last_d      = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_d     = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_LINE;
          char_d      = ram_rdata;
          last_d      = 1'b0;
          idx_d       = idx_next;
          if (idx_next != fill_q) begin
            ram_re    = 1'b1;
            ram_raddr = idx_next[ADDR_W-1:0];
          end
        end
      end
      ST_END: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_END;
          char_d      = CH_NONE;
          last_d      = 1'b1;
          fill_d      = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

endmodule

@@ rtl/core/sle_checker.sv @@
// Port-level assertions for the scancode line editor, bound to its top level.
module sle_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [sle_pkg::SCAN_W-1:0]  scan_code_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [1:0]                  kind_o,
  input logic [sle_pkg::CHAR_W-1:0]  char_code_o,
  input logic                        last_o
);
  import sle_pkg::*;

  // A stalled scancode word holds until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(scan_code_i))
    else $error("scancode word changed while stalled");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(char_code_o) && $stable(last_o))
    else $error("result word changed while stalled");

  // Backspace echoes and end markers carry no character.
  a_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_BACK || kind_o == KIND_END) |-> char_code_o == CH_NONE)
    else $error("character on a kind without one");

  // Line chars are never last; every other kind closes its scancode.
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (kind_o != KIND_LINE)))
    else $error("last flag does not match kind");

  // While a line streams out, no new scancode is taken.
  a_stream_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("scancode accepted during line stream");

endmodule

bind scancode_line_editor sle_checker u_sle_checker (.*);
